FILE: rtl/rbd_pkg.sv
// Package for the 2x2 box downscaler: types, constants and channel arithmetic.
`timescale 1ns / 1ps

package rbd_pkg;

   localparam int PIXEL_WIDTH        = 32;
   localparam int PAIR_WIDTH         = 36;
   localparam int CSR_WIDTH          = 13;
   localparam int CSR_INDEX_WIDTH    = 1;
   localparam int RESET_SIZE         = 1024;
   localparam int DEFAULT_MAX_WIDTH  = 4096;
   localparam int DEFAULT_MAX_HEIGHT = 4096;

   // Register indexes of the CSR port
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_SOURCE_WIDTH  = 1'b0;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_SOURCE_HEIGHT = 1'b1;

   typedef logic [PIXEL_WIDTH-1:0] pixel_type;
   typedef logic [PAIR_WIDTH-1:0]  pair_type;

   // Control that travels with a pair sum from the scan stage to the averaging stage
   typedef struct packed {
      logic emit;      // this request completes an output block
      logic use_self;  // last row of an odd-height image: pair averages with itself
      logic row_end;
      logic image_end;
   } ctl_type;

   // Last position (size - 1) for a register value, zero taken as one, clamped to limit
   function automatic int size_last(input logic [CSR_WIDTH-1:0] value, input int limit);
      int v;
      v = int'(value);
      if (v == 0) begin
         return 0;
      end
      if (v > limit) begin
         return limit - 1;
      end
      return v - 1;
   endfunction

   // Four 9-bit channel sums of two pixels, packed at 9-bit spacing
   function automatic pair_type pair_sum(input pixel_type a, input pixel_type b);
      pair_type r;
      r = '0;
      for (int c = 0; c < 4; c++) begin
         r[9*c +: 9] = 9'(a[8*c +: 8]) + 9'(b[8*c +: 8]);
      end
      return r;
   endfunction

   // Rounded mean of the four pixels held in two packed pair sums, per channel
   function automatic pixel_type block_mean(input pair_type p, input pair_type q);
      pixel_type r;
      logic [10:0] t;
      r = '0;
      for (int c = 0; c < 4; c++) begin
         t = 11'(p[9*c +: 9]) + 11'(q[9*c +: 9]) + 11'd2;
         r[8*c +: 8] = t[9:2];
      end
      return r;
   endfunction

endpackage

FILE: rtl/rbd_if.sv
// Valid/ready channel interfaces for source pixels and downscaled results.
`timescale 1ns / 1ps

interface rbd_req_if
   import rbd_pkg::*;
();
   logic      valid;
   logic      ready;
   pixel_type in_pixel;

   modport source (output valid, output in_pixel, input ready);
   modport sink (input valid, input in_pixel, output ready);
endinterface

interface rbd_rsp_if
   import rbd_pkg::*;
();
   logic      valid;
   logic      ready;
   pixel_type out_pixel;
   logic      row_end;
   logic      image_end;

   modport source (output valid, output out_pixel, output row_end, output image_end,
                   input ready);
   modport sink (input valid, input out_pixel, input row_end, input image_end,
                 output ready);
endinterface

FILE: rtl/rbd_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps

module rbd_ram #(
   parameter int WIDTH      = 36,
   parameter int DEPTH      = 2048,
   parameter int ADDR_WIDTH = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic                  clock,
   input  logic                  wr_en,
   input  logic [ADDR_WIDTH-1:0] wr_addr,
   input  logic [WIDTH-1:0]      wr_data,
   input  logic                  rd_en,
   input  logic [ADDR_WIDTH-1:0] rd_addr,
   output logic [WIDTH-1:0]      rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/rbd_scan.sv
// Raster position tracking, horizontal pair sums and line store access.
`timescale 1ns / 1ps

module rbd_scan
   import rbd_pkg::*;
#(
   parameter int MAX_WIDTH  = DEFAULT_MAX_WIDTH,
   parameter int MAX_HEIGHT = DEFAULT_MAX_HEIGHT,
   parameter int LINE_DEPTH = (MAX_WIDTH + 1) / 2,
   parameter int AW         = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       csr_we,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [CSR_WIDTH-1:0]       csr_wdata,
   input  logic                       accept,
   input  pixel_type                  in_pixel,
   output pair_type                   pair,
   output ctl_type                    ctl,
   output logic                       line_wr_en,
   output logic [AW-1:0]              line_addr,
   output logic                       line_rd_en
);

   localparam int CW = $clog2(MAX_WIDTH);
   localparam int RW = $clog2(MAX_HEIGHT);
   localparam int X_RESET_LAST = (RESET_SIZE > MAX_WIDTH) ? MAX_WIDTH - 1 : RESET_SIZE - 1;
   localparam int Y_RESET_LAST = (RESET_SIZE > MAX_HEIGHT) ? MAX_HEIGHT - 1 : RESET_SIZE - 1;

   logic [CW-1:0] last_x_ff, last_x_in;
   logic [RW-1:0] last_y_ff, last_y_in;
   logic [CW-1:0] col_ff, col_in;
   logic [RW-1:0] row_ff, row_in;
   pixel_type     held_ff, held_in;

   logic x_even, x_last, y_even, y_last, have_pair;

   // Position decode
   always_comb begin
      x_even    = ~col_ff[0];
      x_last    = (col_ff == last_x_ff);
      y_even    = ~row_ff[0];
      y_last    = (row_ff == last_y_ff);
      have_pair = ~x_even | x_last;
      pair      = x_even ? pair_sum(in_pixel, in_pixel) : pair_sum(held_ff, in_pixel);
      line_addr = AW'(col_ff >> 1);
   end

   // Line store access and result control
   always_comb begin
      line_wr_en    = accept & have_pair & y_even & ~y_last;
      line_rd_en    = accept & have_pair & ~y_even;
      ctl.emit      = have_pair & (~y_even | y_last);
      ctl.use_self  = y_even;
      ctl.row_end   = (line_addr == AW'(last_x_ff >> 1));
      ctl.image_end = ctl.row_end & ((row_ff >> 1) == (last_y_ff >> 1));
   end

   // Next state: config writes restart the image, requests advance the scan
   always_comb begin
      last_x_in = last_x_ff;
      last_y_in = last_y_ff;
      col_in    = col_ff;
      row_in    = row_ff;
      held_in   = held_ff;
      if (csr_we) begin
         case (csr_index)
            REG_SOURCE_WIDTH: begin
               last_x_in = CW'(size_last(csr_wdata, MAX_WIDTH));
            end
            REG_SOURCE_HEIGHT: begin
               last_y_in = RW'(size_last(csr_wdata, MAX_HEIGHT));
            end
            default: begin
            end
         endcase
         col_in  = '0;
         row_in  = '0;
         held_in = '0;
      end else if (accept) begin
         if (x_even && !x_last) begin
            held_in = in_pixel;
         end
         if (x_last) begin
            col_in = '0;
            row_in = y_last ? '0 : row_ff + 1'b1;
         end else begin
            col_in = col_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_x_ff <= CW'(X_RESET_LAST);
         last_y_ff <= RW'(Y_RESET_LAST);
         col_ff    <= '0;
         row_ff    <= '0;
         held_ff   <= '0;
      end else begin
         last_x_ff <= last_x_in;
         last_y_ff <= last_y_in;
         col_ff    <= col_in;
         row_ff    <= row_in;
         held_ff   <= held_in;
      end
   end

endmodule

FILE: rtl/rbd_avg.sv
// Averaging stage and output register of the downscaler.
`timescale 1ns / 1ps

module rbd_avg
   import rbd_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     load,
   input  pair_type pair,
   input  ctl_type  ctl,
   input  pair_type line_data,
   output logic     can_load,
   rbd_rsp_if.source rsp
);

   logic     s1_valid_ff, s1_valid_in;
   pair_type s1_pair_ff;
   ctl_type  s1_ctl_ff;
   logic     out_valid_ff, out_valid_in;
   pixel_type out_pixel_ff;
   logic     out_row_end_ff;
   logic     out_image_end_ff;
   logic     s1_adv;

   // Handshake between pair stage and output register
   always_comb begin
      s1_adv       = s1_valid_ff & (~out_valid_ff | rsp.ready);
      can_load     = ~s1_valid_ff | s1_adv;
      s1_valid_in  = load | (s1_valid_ff & ~s1_adv);
      out_valid_in = s1_adv | (out_valid_ff & ~rsp.ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Payload: pair sum held while line store data arrives, then the mean
   always_ff @(posedge clock) begin
      if (load) begin
         s1_pair_ff <= pair;
         s1_ctl_ff  <= ctl;
      end
      if (s1_adv) begin
         out_pixel_ff     <= block_mean(s1_ctl_ff.use_self ? s1_pair_ff : line_data,
                                        s1_pair_ff);
         out_row_end_ff   <= s1_ctl_ff.row_end;
         out_image_end_ff <= s1_ctl_ff.image_end;
      end
   end

   assign rsp.valid     = out_valid_ff;
   assign rsp.out_pixel = out_pixel_ff;
   assign rsp.row_end   = out_row_end_ff;
   assign rsp.image_end = out_image_end_ff;

endmodule

FILE: rtl/rgba_box_downscale_2x.sv
// Top level of the streaming 2x2 box-filter RGBA8 downscaler.
`timescale 1ns / 1ps

// Takes one source pixel per clock in raster order while ready is high and
// returns the half-size image, each channel the rounded mean of a 2x2 block;
// an odd last column or row is paired with itself. A completing request is
// registered in the pair stage, then its result in the output register. One
// request per clock is kept while results are taken; under back-pressure,
// requests stall once both registers are full. Pair sums of even rows wait
// in a line store of (MAX_WIDTH+1)/2 entries, one write, one registered read
// port. Any size write restarts the image; zero acts as one, oversize clamps.

module rgba_box_downscale_2x
   import rbd_pkg::*;
#(
   parameter int MAX_WIDTH  = DEFAULT_MAX_WIDTH,
   parameter int MAX_HEIGHT = DEFAULT_MAX_HEIGHT
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       csr_we,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [CSR_WIDTH-1:0]       csr_wdata,
   rbd_req_if.sink                    req_ch,
   rbd_rsp_if.source                  rsp_ch
);

   localparam int LINE_DEPTH = (MAX_WIDTH + 1) / 2;
   localparam int AW         = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1;

   logic          accept;
   logic          can_load;
   pair_type      pair;
   ctl_type       ctl;
   logic          line_wr_en;
   logic          line_rd_en;
   logic [AW-1:0] line_addr;
   pair_type      line_data;

   assign req_ch.ready = can_load;
   assign accept       = req_ch.valid & can_load;

   rbd_scan #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT),
      .LINE_DEPTH (LINE_DEPTH),
      .AW         (AW)
   ) u_scan (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .accept     (accept),
      .in_pixel   (req_ch.in_pixel),
      .pair       (pair),
      .ctl        (ctl),
      .line_wr_en (line_wr_en),
      .line_addr  (line_addr),
      .line_rd_en (line_rd_en)
   );

   rbd_ram #(
      .WIDTH      (PAIR_WIDTH),
      .DEPTH      (LINE_DEPTH),
      .ADDR_WIDTH (AW)
   ) u_line (
      .clock   (clock),
      .wr_en   (line_wr_en),
      .wr_addr (line_addr),
      .wr_data (pair),
      .rd_en   (line_rd_en),
      .rd_addr (line_addr),
      .rd_data (line_data)
   );

   rbd_avg u_avg (
      .clock     (clock),
      .reset     (reset),
      .load      (accept & ctl.emit),
      .pair      (pair),
      .ctl       (ctl),
      .line_data (line_data),
      .can_load  (can_load),
      .rsp       (rsp_ch)
   );

endmodule

FILE: bench/tb_rgba_box_downscale_2x.sv
// Self-checking testbench for the 2x2 box-filter RGBA8 downscaler.
`timescale 1ns / 1ps

module tb_rgba_box_downscale_2x;
   import rbd_pkg::*;

   localparam int          MAX_W           = DEFAULT_MAX_WIDTH;
   localparam int          MAX_H           = DEFAULT_MAX_HEIGHT;
   localparam int          LINE_DEPTH      = (MAX_W + 1) / 2;
   localparam int          LINE_AW         = $clog2(LINE_DEPTH);
   localparam int          SETTLE_CYCLES   = 8;
   localparam int          HOLD_OFF_CYCLES = 400;
   localparam int          RESET_ITEMS     = 16;
   localparam int          EXTREME_ITEMS   = 40;
   localparam int          RANDOM_ITEMS    = 150;
   localparam int          REPORT_LIMIT    = 10;
   localparam int unsigned CYCLE_LIMIT     = 1_000_000;

   // One downscaled pixel with its end-of-row and end-of-image flags
   typedef struct packed {
      pixel_type pixel;
      logic      row_end;
      logic      image_end;
   } scaled_pixel_type;

   logic                       clock = 1'b0;
   logic                       reset = 1'b1;
   logic                       csr_we;
   logic [CSR_INDEX_WIDTH-1:0] csr_index;
   logic [CSR_WIDTH-1:0]       csr_wdata;

   rbd_req_if req_ch ();
   rbd_rsp_if rsp_ch ();

   rgba_box_downscale_2x dut (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_ch    (req_ch),
      .rsp_ch    (rsp_ch)
   );

   // 12 ns clock
   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Predictor state: size registers, scan position, held pixel, line of pair sums
   logic [CSR_WIDTH-1:0] width_reg  = CSR_WIDTH'(RESET_SIZE);
   logic [CSR_WIDTH-1:0] height_reg = CSR_WIDTH'(RESET_SIZE);
   int unsigned          col_pos    = 0;
   int unsigned          row_pos    = 0;
   pixel_type            held_px    = '0;
   pair_type             upper_pairs [LINE_DEPTH];

   scaled_pixel_type expected_pixels[$];
   int unsigned      mismatch_count = 0;
   int unsigned      burst_left     = 0;
   bit               steady_send    = 1'b0;
   bit               hold_request   = 1'b0;

   // Zero acts as one, oversize clamps to the limit
   function automatic int unsigned clamp_size(input logic [CSR_WIDTH-1:0] v,
                                              input int unsigned limit);
      if (v == '0) begin
         return 1;
      end
      return (v > limit) ? limit : int'(v);
   endfunction

   // Per-channel sums of two pixels, 9 bits each
   function automatic pair_type add_pixels(input pixel_type a, input pixel_type b);
      pair_type s;
      s = '0;
      for (int c = 0; c < 4; c++) begin
         s[9*c +: 9] = {1'b0, a[8*c +: 8]} + {1'b0, b[8*c +: 8]};
      end
      return s;
   endfunction

   // Rounded average of four pixels given as two rows of pair sums
   function automatic pixel_type round_quad(input pair_type upper, input pair_type lower);
      pixel_type r;
      int        t;
      r = '0;
      for (int c = 0; c < 4; c++) begin
         t = int'(upper[9*c +: 9]) + int'(lower[9*c +: 9]);
         r[8*c +: 8] = 8'((t + 2) / 4);
      end
      return r;
   endfunction

   // Advance the scan by one source pixel; queue the averaged pixel it completes
   function automatic void predict_block_mean(input pixel_type px);
      int unsigned      w;
      int unsigned      h;
      int unsigned      x;
      int unsigned      y;
      int unsigned      ox;
      bit               have_pair;
      pair_type         pair;
      scaled_pixel_type r;
      w = clamp_size(width_reg, MAX_W);
      h = clamp_size(height_reg, MAX_H);
      x = col_pos;
      y = row_pos;
      have_pair = 1'b0;
      pair = '0;
      if (x % 2 == 0) begin
         if (x + 1 >= w) begin
            pair = add_pixels(px, px);
            have_pair = 1'b1;
         end else begin
            held_px = px;
         end
      end else begin
         pair = add_pixels(held_px, px);
         have_pair = 1'b1;
      end
      if (have_pair) begin
         ox = x / 2;
         if (y % 2 == 0 && y + 1 < h) begin
            upper_pairs[LINE_AW'(ox)] = pair;
         end else begin
            // last row of an odd height pairs with itself
            r.pixel     = (y % 2 == 0) ? round_quad(pair, pair)
                                       : round_quad(upper_pairs[LINE_AW'(ox)], pair);
            r.row_end   = (ox == (w - 1) / 2);
            r.image_end = r.row_end && (y / 2 == (h - 1) / 2);
            expected_pixels.push_back(r);
         end
      end
      // wrap to a new row after the last column, and to a new image after the last pixel
      if (x + 1 >= w) begin
         col_pos = 0;
         row_pos = (y + 1 >= h) ? 0 : y + 1;
      end else begin
         col_pos = x + 1;
      end
   endfunction

   // Result checker: compare each accepted result with the oldest expectation
   always @(posedge clock) begin
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin : check_result
         scaled_pixel_type want;
         if (expected_pixels.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= REPORT_LIMIT) begin
               $display("unexpected result: pixel %h row_end %b image_end %b",
                        rsp_ch.out_pixel, rsp_ch.row_end, rsp_ch.image_end);
            end
         end else begin
            want = expected_pixels.pop_front();
            if (rsp_ch.out_pixel !== want.pixel || rsp_ch.row_end !== want.row_end
                || rsp_ch.image_end !== want.image_end) begin
               mismatch_count++;
               if (mismatch_count <= REPORT_LIMIT) begin
                  $display("mismatch: expected pixel %h row_end %b image_end %b, got %h %b %b",
                           want.pixel, want.row_end, want.image_end,
                           rsp_ch.out_pixel, rsp_ch.row_end, rsp_ch.image_end);
               end
            end
         end
      end
   end

   // Result sink: changing stall pattern, plus a long hold-off on request
   initial begin : result_sink
      int unsigned hold_left;
      int unsigned mode_left;
      int unsigned mode;
      int unsigned tick;
      hold_left = 0;
      mode_left = 0;
      mode = 0;
      tick = 0;
      rsp_ch.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_request) begin
            hold_left = HOLD_OFF_CYCLES;
            hold_request = 1'b0;
         end
         if (mode_left == 0) begin
            mode = $urandom_range(0, 3);
            mode_left = $urandom_range(20, 120);
         end
         mode_left--;
         tick++;
         if (hold_left > 0) begin
            hold_left--;
            rsp_ch.ready <= 1'b0;
         end else begin
            case (mode)
               0: rsp_ch.ready <= 1'b1;
               1: rsp_ch.ready <= ($urandom_range(0, 3) != 0);
               2: rsp_ch.ready <= (tick % 5 < 2);
               default: rsp_ch.ready <= 1'($urandom_range(0, 1));
            endcase
         end
      end
   end

   // Watchdog
   initial begin : watchdog
      repeat (CYCLE_LIMIT) @(posedge clock);
      $display("FAIL rgba_box_downscale_2x");
      $finish;
   end

   // Offer one source pixel, called at a falling edge; returns at the falling edge after
   task automatic send_pixel(input pixel_type px);
      int unsigned gap;
      if (!steady_send && burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         if (gap > 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         burst_left = $urandom_range(1, 24);
      end
      req_ch.valid    <= 1'b1;
      req_ch.in_pixel <= px;
      do @(posedge clock); while (!req_ch.ready);
      predict_block_mean(px);
      if (burst_left > 0) begin
         burst_left--;
      end
      @(negedge clock);
   endtask

   // Random pixel, biased toward all-zero and all-one channels
   function automatic pixel_type random_pixel();
      pixel_type p;
      case ($urandom_range(0, 5))
         0: p = '0;
         1: p = '1;
         2: begin
            for (int c = 0; c < 4; c++) begin
               p[8*c +: 8] = ($urandom_range(0, 1) != 0) ? 8'hFF : 8'h00;
            end
         end
         default: p = $urandom;
      endcase
      return p;
   endfunction

   task automatic send_random_pixels(input int unsigned count);
      for (int unsigned i = 0; i < count; i++) begin
         send_pixel(random_pixel());
      end
   endtask

   // Drop valid, wait for all expected results, then let the pipeline drain
   task automatic settle_idle();
      req_ch.valid <= 1'b0;
      while (expected_pixels.size() != 0) begin
         @(negedge clock);
      end
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // Register write; any write restarts the image
   task automatic write_reg(input logic [CSR_INDEX_WIDTH-1:0] index,
                            input logic [CSR_WIDTH-1:0] value);
      csr_we    <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      @(negedge clock);
      csr_we <= 1'b0;
      if (index == REG_SOURCE_WIDTH) begin
         width_reg = value;
      end else begin
         height_reg = value;
      end
      col_pos = 0;
      row_pos = 0;
      held_px = '0;
      @(negedge clock);
   endtask

   task automatic set_size(input logic [CSR_WIDTH-1:0] w, input logic [CSR_WIDTH-1:0] h);
      write_reg(REG_SOURCE_WIDTH, w);
      write_reg(REG_SOURCE_HEIGHT, h);
   endtask

   // Sizes after reset: the start of the first row at the default width gives no result
   task automatic test_reset_size();
      send_random_pixels(RESET_ITEMS);
      settle_idle();
   endtask

   // Known values: black, white, rounding edges, alternating bits, odd 3x3 image
   task automatic test_directed_values();
      set_size(13'd2, 13'd2);
      repeat (4) send_pixel(32'h0000_0000);
      repeat (4) send_pixel(32'hFFFF_FFFF);
      // per channel sums 1, 2, 3 and 1019 exercise rounding
      send_pixel(32'hFF01_0000);
      send_pixel(32'hFF01_0000);
      send_pixel(32'hFF01_0100);
      send_pixel(32'hFE00_0101);
      send_pixel(32'h55AA_55AA);
      send_pixel(32'hAA55_AA55);
      send_pixel(32'hAA55_AA55);
      send_pixel(32'h55AA_55AA);
      settle_idle();
      set_size(13'd3, 13'd3);
      send_random_pixels(9);
      settle_idle();
   endtask

   // Zero sizes, saturated sizes and the start of a full-width row
   task automatic test_size_extremes();
      set_size(13'd0, 13'd0);
      send_random_pixels(3);
      settle_idle();
      set_size(13'd8191, 13'd1);
      send_random_pixels(EXTREME_ITEMS);
      settle_idle();
      set_size(13'd1, 13'd8191);
      send_random_pixels(EXTREME_ITEMS);
      settle_idle();
      set_size(CSR_WIDTH'(MAX_W), 13'd1);
      send_random_pixels(EXTREME_ITEMS);
      settle_idle();
   endtask

   // A register write in the middle of an image starts a fresh one
   task automatic test_restart_mid_image();
      set_size(13'd5, 13'd4);
      send_random_pixels(7);
      settle_idle();
      write_reg(REG_SOURCE_WIDTH, 13'd5);
      send_random_pixels(1);
      settle_idle();
      write_reg(REG_SOURCE_HEIGHT, 13'd4);
      send_random_pixels(20);
      settle_idle();
   endtask

   // Long result stall while requests keep coming: input must back up
   task automatic test_output_hold_off();
      set_size(13'd2, 13'd2);
      steady_send = 1'b1;
      hold_request = 1'b1;
      send_random_pixels(64);
      steady_send = 1'b0;
      settle_idle();
   endtask

   // Random small images, some cut short, some back to back
   task automatic test_random_images();
      int unsigned sent;
      int unsigned w;
      int unsigned h;
      int unsigned count;
      sent = 0;
      while (sent < RANDOM_ITEMS) begin
         w = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 48) : $urandom_range(0, 12);
         h = $urandom_range(0, 8);
         if ($urandom_range(0, 1) != 0) begin
            set_size(CSR_WIDTH'(w), CSR_WIDTH'(h));
         end else begin
            write_reg(REG_SOURCE_HEIGHT, CSR_WIDTH'(h));
            write_reg(REG_SOURCE_WIDTH, CSR_WIDTH'(w));
         end
         count = clamp_size(CSR_WIDTH'(w), MAX_W) * clamp_size(CSR_WIDTH'(h), MAX_H);
         case ($urandom_range(0, 7))
            0: count = $urandom_range(1, count);
            1: count = 2 * count;
            default: ;
         endcase
         if (count > RANDOM_ITEMS - sent) begin
            count = RANDOM_ITEMS - sent;
         end
         steady_send = ($urandom_range(0, 3) == 0);
         send_random_pixels(count);
         steady_send = 1'b0;
         sent += count;
         settle_idle();
      end
   endtask

   // Test sequence
   initial begin
      req_ch.valid    = 1'b0;
      req_ch.in_pixel = '0;
      csr_we          = 1'b0;
      csr_index       = '0;
      csr_wdata       = '0;
      for (int i = 0; i < LINE_DEPTH; i++) begin
         upper_pairs[LINE_AW'(i)] = '0;
      end
      repeat (11) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      test_reset_size();
      test_directed_values();
      test_size_extremes();
      test_restart_mid_image();
      test_output_hold_off();
      test_random_images();
      settle_idle();

      if (mismatch_count == 0) begin
         $display("PASS rgba_box_downscale_2x");
      end else begin
         $display("FAIL rgba_box_downscale_2x");
      end
      $finish;
   end

endmodule

FILE: filelist.f
rtl/rbd_pkg.sv
rtl/rbd_if.sv
rtl/rbd_ram.sv
rtl/rbd_scan.sv
rtl/rbd_avg.sv
rtl/rgba_box_downscale_2x.sv
bench/tb_rgba_box_downscale_2x.sv
